### design/refcounted_handle_table_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the refcounted handle table core
// Shared property forms: same-cycle and next-cycle implication under reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_TABLE_CORE_DEFINES_SVH
`define REFCOUNTED_HANDLE_TABLE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rcht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcht_pkg
// Types, sizes and codes shared by the refcounted handle table modules.
// ----------------------------------------------------------------------------
package rcht_pkg;

    localparam int SLOTS         = 16;
    localparam int NAME_BYTES    = 8;
    localparam int DEPS_PER_SLOT = 8;
    localparam int ID_BITS       = 16;

    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NAME_W   = 8 * NAME_BYTES;
    localparam int DCNT_W   = $clog2(DEPS_PER_SLOT + 1);
    localparam int DEP_W    = (DEPS_PER_SLOT > 1) ? $clog2(DEPS_PER_SLOT) : 1;
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 16;
    localparam int REFS_W   = 16;
    localparam int LIVE_W   = 5;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ADDREF = 2'd1,
        ACT_UNLOAD = 2'd2,
        ACT_ADDDEP = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NOT_FOUND  = 3'd1,
        STAT_TABLE_FULL = 3'd2,
        STAT_DEPS_FULL  = 3'd3,
        STAT_IN_USE     = 3'd4,
        STAT_BAD_HANDLE = 3'd5
    } t_status;

    typedef struct packed {
        t_action               action;
        logic [KEY_W-1:0]      key_name;
        logic [HANDLE_W-1:0]   handle;
        logic [HANDLE_W-1:0]   dep_hdl;
    } t_in_word;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   handle_out;
        logic [LIVE_W-1:0]     live_count;
    } t_out_word;

    typedef struct packed {
        logic [ID_BITS-1:0]    handle;
        logic [NAME_W-1:0]     name;
        logic [REFS_W-1:0]     refs;
        logic [DCNT_W-1:0]     dep_cnt;
    } t_meta;

    typedef logic [DEPS_PER_SLOT-1:0][ID_BITS-1:0] t_dep_row;

    typedef struct packed {
        logic                  meta_we;
        logic                  row_we;
        logic                  clr;
        logic [SLOT_W-1:0]     addr;
        t_meta                 meta;
        t_dep_row              row;
    } t_store_wr;

    typedef struct packed {
        logic                  en;
        logic [SLOT_W-1:0]     addr;
    } t_store_rd;

    typedef struct packed {
        logic                  valid;
        t_meta                 meta;
        t_dep_row              row;
    } t_store_rsp;

endpackage

### design/rcht_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcht_store
// Slot memory and dependency row memory, one read and one write port each,
// registered read data. Per-slot occupied bits in flops.
// ----------------------------------------------------------------------------
module rcht_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rcht_pkg::t_store_rd    i_rd,
    input  rcht_pkg::t_store_wr    i_wr,
    output rcht_pkg::t_store_rsp   o_rsp
);
    import rcht_pkg::*;

    t_meta              r_meta [SLOTS];
    t_dep_row           r_rows [SLOTS];
    logic [SLOTS-1:0]   r_valid;
    logic               r_rsp_valid;
    t_meta              r_rsp_meta;
    t_dep_row           r_rsp_row;

    always_ff @(posedge i_clk) begin
        if (i_wr.meta_we) begin
            r_meta[i_wr.addr] <= i_wr.meta;
        end
        if (i_wr.row_we) begin
            r_rows[i_wr.addr] <= i_wr.row;
        end
        if (i_rd.en) begin
            r_rsp_meta <= r_meta[i_rd.addr];
            r_rsp_row  <= r_rows[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_wr.meta_we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end else if (i_wr.clr) begin
                r_valid[i_wr.addr] <= 1'b0;
            end
            if (i_rd.en) begin
                r_rsp_valid <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.meta  = r_rsp_meta;
    assign o_rsp.row   = r_rsp_row;

endmodule

### design/rcht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcht_ctrl
// Sequencer: scans every slot through the store, collects matches, then
// applies the operation with at most one write back and issues the result word.
// ----------------------------------------------------------------------------
module rcht_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  rcht_pkg::t_in_word     i_in_data,
    output logic                   o_in_stall,
    output rcht_pkg::t_store_rd    o_rd,
    input  rcht_pkg::t_store_rsp   i_rsp,
    output rcht_pkg::t_store_wr    o_wr,
    input  logic                   i_res_free,
    output logic                   o_res_valid,
    output rcht_pkg::t_out_word    o_res
);
    import rcht_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state              r_state;
    t_in_word            r_item;
    logic [NAME_W-1:0]   r_key;
    logic [SLOT_W:0]     r_idx;
    logic                r_pend;
    logic [SLOT_W-1:0]   r_pidx;
    logic [LIVE_W-1:0]   r_occ;
    logic [ID_BITS-1:0]  r_next;

    logic                r_name_hit;
    logic [SLOT_W-1:0]   r_name_idx;
    t_meta               r_name_meta;
    logic                r_free_hit;
    logic [SLOT_W-1:0]   r_free_idx;
    logic                r_h_hit;
    logic [SLOT_W-1:0]   r_h_idx;
    t_meta               r_h_meta;
    t_dep_row            r_h_row;
    logic                r_dh_hit;
    logic                r_dep_on;

    logic                name_eq;
    logic                h_eq;
    logic                dh_eq;
    logic                dep_eq;
    logic                last;
    logic                fire;

    logic [LIVE_W-1:0]   n_occ;
    logic [ID_BITS-1:0]  n_next;
    logic [ID_BITS-1:0]  new_h;
    logic [REFS_W-1:0]   refs_inc;
    logic [REFS_W-1:0]   refs_dec;
    logic                dup;
    t_store_wr           wr;
    t_out_word           res;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd.en    = (r_state == S_SCAN) && (r_idx < (SLOT_W + 1)'(SLOTS));
    assign o_rd.addr  = r_idx[SLOT_W-1:0];

    // per-slot compares on the word just read
    always_comb begin
        name_eq = i_rsp.valid && (i_rsp.meta.name == r_key);
        h_eq    = i_rsp.valid && (HANDLE_W'(i_rsp.meta.handle) == r_item.handle);
        dh_eq   = i_rsp.valid && (HANDLE_W'(i_rsp.meta.handle) == r_item.dep_hdl);
        dep_eq  = 1'b0;
        for (int d = 0; d < DEPS_PER_SLOT; d++) begin
            if ((DCNT_W'(d) < i_rsp.meta.dep_cnt)
                && (HANDLE_W'(i_rsp.row[d]) == r_item.handle)) begin
                dep_eq = i_rsp.valid;
            end
        end
    end

    assign last = r_pend && (r_pidx == SLOT_W'(SLOTS - 1));
    assign fire = (r_state == S_FINAL) && i_res_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_occ   <= '0;
            r_next  <= ID_BITS'(1);
        end else begin
            r_pend <= o_rd.en;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (last) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                        r_occ   <= n_occ;
                        r_next  <= n_next;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // scan bookkeeping: keep the lowest slot for each name, free and handle match
    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx[SLOT_W-1:0];
        if (r_state == S_IDLE) begin
            r_item     <= i_in_data;
            r_key      <= i_in_data.key_name[NAME_W-1:0];
            r_idx      <= '0;
            r_name_hit <= 1'b0;
            r_free_hit <= 1'b0;
            r_h_hit    <= 1'b0;
            r_dh_hit   <= 1'b0;
            r_dep_on   <= 1'b0;
        end else begin
            if (o_rd.en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pend) begin
                if (name_eq && !r_name_hit) begin
                    r_name_hit  <= 1'b1;
                    r_name_idx  <= r_pidx;
                    r_name_meta <= i_rsp.meta;
                end
                if (!i_rsp.valid && !r_free_hit) begin
                    r_free_hit <= 1'b1;
                    r_free_idx <= r_pidx;
                end
                if (h_eq && !r_h_hit) begin
                    r_h_hit  <= 1'b1;
                    r_h_idx  <= r_pidx;
                    r_h_meta <= i_rsp.meta;
                    r_h_row  <= i_rsp.row;
                end
                if (dh_eq) begin
                    r_dh_hit <= 1'b1;
                end
                if (dep_eq) begin
                    r_dep_on <= 1'b1;
                end
            end
        end
    end

    // apply the operation
    always_comb begin
        n_occ    = r_occ;
        n_next   = r_next;
        wr       = '0;
        res      = '0;
        res.status = STAT_OK;
        new_h    = (r_next == '0) ? ID_BITS'(1) : r_next;
        refs_inc = '0;
        refs_dec = (r_h_meta.refs != '0) ? r_h_meta.refs - 1'b1 : '0;
        dup      = 1'b0;
        for (int d = 0; d < DEPS_PER_SLOT; d++) begin
            if ((DCNT_W'(d) < r_h_meta.dep_cnt)
                && (HANDLE_W'(r_h_row[d]) == r_item.dep_hdl)) begin
                dup = 1'b1;
            end
        end
        unique case (r_item.action)
            ACT_LOAD: begin
                if (r_name_hit) begin
                    refs_inc = (r_name_meta.refs != REFS_MAX)
                             ? r_name_meta.refs + 1'b1 : r_name_meta.refs;
                    wr.meta_we   = 1'b1;
                    wr.addr      = r_name_idx;
                    wr.meta      = r_name_meta;
                    wr.meta.refs = refs_inc;
                    res.handle_out = HANDLE_W'(r_name_meta.handle);
                end else if (r_free_hit) begin
                    n_next = new_h + 1'b1;
                    if (n_next == '0) begin
                        n_next = ID_BITS'(1);
                    end
                    wr.meta_we      = 1'b1;
                    wr.addr         = r_free_idx;
                    wr.meta.handle  = new_h;
                    wr.meta.name    = r_key;
                    wr.meta.refs    = REFS_W'(1);
                    wr.meta.dep_cnt = '0;
                    n_occ = r_occ + 1'b1;
                    res.handle_out = HANDLE_W'(new_h);
                end else begin
                    res.status = STAT_TABLE_FULL;
                end
            end
            ACT_ADDREF, ACT_UNLOAD: begin
                if (r_item.handle == '0) begin
                    res.status = STAT_BAD_HANDLE;
                end else if (!r_h_hit) begin
                    res.status = STAT_NOT_FOUND;
                end else if (r_item.action == ACT_ADDREF) begin
                    wr.meta_we   = 1'b1;
                    wr.addr      = r_h_idx;
                    wr.meta      = r_h_meta;
                    wr.meta.refs = (r_h_meta.refs != REFS_MAX)
                                 ? r_h_meta.refs + 1'b1 : r_h_meta.refs;
                end else if (refs_dec != '0 || r_dep_on) begin
                    // decrement the count; hold the slot at zero while something depends on it
                    wr.meta_we   = 1'b1;
                    wr.addr      = r_h_idx;
                    wr.meta      = r_h_meta;
                    wr.meta.refs = refs_dec;
                    if (refs_dec == '0) begin
                        res.status = STAT_IN_USE;
                    end
                end else begin
                    wr.clr  = 1'b1;
                    wr.addr = r_h_idx;
                    if (r_occ != '0) begin
                        n_occ = r_occ - 1'b1;
                    end
                end
            end
            ACT_ADDDEP: begin
                if (r_item.handle == '0 || r_item.dep_hdl == '0) begin
                    res.status = STAT_BAD_HANDLE;
                end else if (!r_h_hit || !r_dh_hit) begin
                    res.status = STAT_NOT_FOUND;
                end else if (!dup) begin
                    if (r_h_meta.dep_cnt >= DCNT_W'(DEPS_PER_SLOT)) begin
                        res.status = STAT_DEPS_FULL;
                    end else begin
                        wr.meta_we      = 1'b1;
                        wr.row_we       = 1'b1;
                        wr.addr         = r_h_idx;
                        wr.meta         = r_h_meta;
                        wr.meta.dep_cnt = r_h_meta.dep_cnt + 1'b1;
                        wr.row          = r_h_row;
                        wr.row[r_h_meta.dep_cnt[DEP_W-1:0]] = ID_BITS'(r_item.dep_hdl);
                    end
                end
            end
            default: res.status = STAT_OK;
        endcase
        res.live_count = n_occ;
    end

    assign o_wr        = fire ? wr : '0;
    assign o_res_valid = fire;
    assign o_res       = res;

endmodule

### design/refcounted_handle_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_handle_table_core
// Slot table of handles with reference counts and dependency lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one operation word
//   (load by name, add reference, unload, add dependency). Output channel:
//   o_out_valid / i_out_stall carry one result word per operation
//   (status, handle, live slot count).
//   Each operation scans all SLOTS slots through the slot memory's single
//   read port, one slot a cycle, then writes back at most once. The result
//   is registered once the scan is done, and the next word is taken the
//   cycle after the result is registered, so a new operation is taken only
//   after the previous one has finished.
//   The result sits in an output register; a stalled receiver holds it and
//   the next operation may be taken and scanned meanwhile, finishing only
//   once that register is free.
//   Reset (synchronous, active low) frees all slots, clears the live count
//   and sets the next handle to one; it is ready the cycle after.
// ----------------------------------------------------------------------------
module refcounted_handle_table_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rcht_pkg::t_in_word     i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rcht_pkg::t_out_word    o_out_data
);
    import rcht_pkg::*;

    t_store_rd    rd;
    t_store_wr    wr;
    t_store_rsp   rsp;
    logic         res_valid;
    t_out_word    res;
    logic         res_free;
    logic         r_out_valid;
    t_out_word    r_out_data;

    assign res_free = !r_out_valid || !i_out_stall;

    rcht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_rd        (rd),
        .i_rsp       (rsp),
        .o_wr        (wr),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rcht_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_wr    (wr),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### design/rcht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcht_checker
// Port-level checks of the handle table core, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcounted_handle_table_core_defines.svh"

module rcht_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  rcht_pkg::t_out_word    i_out_data
);
    import rcht_pkg::*;

    `RCHT_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data), "stalled result word changed")
    `RCHT_ASSERT_NEXT(a_busy_after_take, i_in_valid && !i_in_stall, i_in_stall, "second word taken during scan")
    `RCHT_ASSERT_NOW(a_handle_on_ok, i_out_valid && i_out_data.status != STAT_OK, i_out_data.handle_out == '0, "handle given with error status")
    `RCHT_ASSERT_NOW(a_live_bound, i_out_valid, i_out_data.live_count <= LIVE_W'(SLOTS), "live count above slot count")

endmodule

bind refcounted_handle_table_core rcht_checker u_rcht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the refcounted handle table core against a behavioral slot table:
// directed corner operations, then mostly well-formed random traffic on a
// small name pool, with random idling on both channels and a long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import rcht_pkg::*;

    localparam int NSLOT   = 16;
    localparam int NDEP    = 8;
    localparam int WD_MAX  = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_data;

    refcounted_handle_table_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // behavioral copy of the table
    logic [15:0] tbl_handle [NSLOT];
    logic [63:0] tbl_name   [NSLOT];
    logic [15:0] tbl_refs   [NSLOT];
    int          tbl_ndeps  [NSLOT];
    logic [15:0] tbl_deps   [NSLOT][NDEP];
    logic [15:0] next_hid;
    int          live_slots;

    t_in_word    pending_ops[$];
    t_out_word   expected_results[$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          ops_sent = 0;
    int          idle_cycles = 0;
    bit          quiet_phase = 1'b0;
    bit          hold_req = 1'b0;
    bit          sender_pause = 1'b0;
    bit          rst_done = 1'b0;
    int          status_hits [8];

    function automatic int find_handle(logic [15:0] h);
        if (h == 0) return -1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic bit is_depended(logic [15:0] h);
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_handle[i] == 0) continue;
            for (int d = 0; d < tbl_ndeps[i]; d++)
                if (tbl_deps[i][d] == h) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_word apply_table_op(t_in_word op);
        t_out_word r;
        int s;
        bit dup;
        r = '0;
        r.status = STAT_OK;
        s = -1;
        case (op.action)
            ACT_LOAD: begin
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && tbl_handle[i] != 0 && tbl_name[i] == op.key_name) s = i;
                if (s >= 0) begin
                    if (tbl_refs[s] != 16'hFFFF) tbl_refs[s]++;
                    r.handle_out = tbl_handle[s];
                end else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (s < 0 && tbl_handle[i] == 0) s = i;
                    if (s < 0) begin
                        r.status = STAT_TABLE_FULL;
                    end else begin
                        if (next_hid == 0) next_hid = 1;
                        tbl_handle[s] = next_hid;
                        tbl_name[s] = op.key_name;
                        tbl_refs[s] = 1;
                        tbl_ndeps[s] = 0;
                        live_slots++;
                        r.handle_out = next_hid;
                        next_hid = next_hid + 1;
                        if (next_hid == 0) next_hid = 1;
                    end
                end
            end
            ACT_ADDREF, ACT_UNLOAD: begin
                s = find_handle(op.handle);
                if (op.handle == 0) begin
                    r.status = STAT_BAD_HANDLE;
                end else if (s < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else if (op.action == ACT_ADDREF) begin
                    if (tbl_refs[s] != 16'hFFFF) tbl_refs[s]++;
                end else begin
                    if (tbl_refs[s] != 0) tbl_refs[s]--;
                    if (tbl_refs[s] == 0) begin
                        if (is_depended(op.handle)) begin
                            r.status = STAT_IN_USE;
                        end else begin
                            tbl_handle[s] = 0;
                            tbl_name[s] = 0;
                            tbl_ndeps[s] = 0;
                            if (live_slots > 0) live_slots--;
                        end
                    end
                end
            end
            default: begin
                s = find_handle(op.handle);
                if (op.handle == 0 || op.dep_hdl == 0) begin
                    r.status = STAT_BAD_HANDLE;
                end else if (s < 0 || find_handle(op.dep_hdl) < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    dup = 1'b0;
                    for (int d = 0; d < tbl_ndeps[s]; d++)
                        if (tbl_deps[s][d] == op.dep_hdl) dup = 1'b1;
                    if (!dup) begin
                        if (tbl_ndeps[s] >= NDEP) begin
                            r.status = STAT_DEPS_FULL;
                        end else begin
                            tbl_deps[s][tbl_ndeps[s]] = op.dep_hdl;
                            tbl_ndeps[s]++;
                        end
                    end
                end
            end
        endcase
        r.live_count = live_slots[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // driver: predict at acceptance, then advance
    always @(posedge i_clk) begin
        if (rst_done) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(apply_table_op(i_in_data));
                ops_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_ops.size() > 0 && !sender_pause &&
                    (quiet_phase || $urandom_range(99) >= 12)) begin
                    i_in_data  <= pending_ops.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_out_word want;
        if (rst_done) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result status", 16'(o_out_data.status),
                                    16'h0);
                end else begin
                    want = expected_results.pop_front();
                    status_hits[want.status]++;
                    if (o_out_data.status != want.status)
                        report_mismatch("status", 16'(o_out_data.status), 16'(want.status));
                    if (o_out_data.handle_out != want.handle_out)
                        report_mismatch("handle_out", o_out_data.handle_out, want.handle_out);
                    if (o_out_data.live_count != want.live_count)
                        report_mismatch("live_count", 16'(o_out_data.live_count),
                                        16'(want.live_count));
                end
            end
            i_out_stall <= hold_req || (!quiet_phase && $urandom_range(99) < 12);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_MAX) begin
            $display("Watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_in_word make_op(t_action a, logic [63:0] k,
                                         logic [15:0] h, logic [15:0] dh);
        t_in_word w;
        w.action = a;
        w.key_name = k;
        w.handle = h;
        w.dep_hdl = dh;
        return w;
    endfunction

    // handles seen so far by the random stream are small; guess near them
    function automatic logic [15:0] pick_handle(int hi);
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'h0;
        if (r < 10) return 16'($urandom);
        return 16'($urandom_range(hi, (hi > 20) ? hi - 20 : 1));
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int hi;
        int r;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_handle[i] = 0; tbl_name[i] = 0; tbl_refs[i] = 0; tbl_ndeps[i] = 0;
        end
        next_hid = 1;
        live_slots = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // directed: bad handles, unknown handles, extreme keys
        pending_ops.push_back(make_op(ACT_ADDREF, 64'h0, 16'h0, 16'h0));
        pending_ops.push_back(make_op(ACT_UNLOAD, 64'h0, 16'hFFFF, 16'h0));
        pending_ops.push_back(make_op(ACT_ADDDEP, 64'h0, 16'h1, 16'h0));
        pending_ops.push_back(make_op(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF));
        pending_ops.push_back(make_op(ACT_LOAD, 64'h0, 16'h0, 16'h0));
        pending_ops.push_back(make_op(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0));
        // self dependency, then held slot
        pending_ops.push_back(make_op(ACT_ADDDEP, 64'h0, 16'h1, 16'h1));
        pending_ops.push_back(make_op(ACT_ADDDEP, 64'h0, 16'h2, 16'h1));
        pending_ops.push_back(make_op(ACT_ADDDEP, 64'h0, 16'h2, 16'h1));
        pending_ops.push_back(make_op(ACT_ADDDEP, 64'h0, 16'h2, 16'h7));
        pending_ops.push_back(make_op(ACT_UNLOAD, 64'h0, 16'h1, 16'h0));
        pending_ops.push_back(make_op(ACT_UNLOAD, 64'h0, 16'h1, 16'h0));
        pending_ops.push_back(make_op(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0));
        pending_ops.push_back(make_op(ACT_UNLOAD, 64'h0, 16'h2, 16'h0));
        pending_ops.push_back(make_op(ACT_UNLOAD, 64'h0, 16'h2, 16'h0));
        // fill the table, then one more new name
        for (int i = 0; i < 15; i++)
            pending_ops.push_back(make_op(ACT_LOAD, 64'(i + 100), 16'h0, 16'h0));
        pending_ops.push_back(make_op(ACT_LOAD, 64'h5555_AAAA_0000_0001, 16'h0, 16'h0));
        // fill a dependency list past its end
        for (int i = 0; i < 10; i++)
            pending_ops.push_back(make_op(ACT_ADDDEP, 64'h0, 16'h3, 16'(i + 3)));
        wait_drained();

        // sender pause after every result is back
        sender_pause = 1'b1;
        repeat (40) @(posedge i_clk);
        sender_pause = 1'b0;

        // receiver holds off while the sender keeps offering
        for (int i = 0; i < 8; i++)
            pending_ops.push_back(make_op(ACT_ADDREF, 64'h0, 16'(i + 3), 16'h0));
        hold_req = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_req = 1'b0;
        wait_drained();

        // repeated add references on one slot, without idling
        quiet_phase = 1'b1;
        for (int i = 0; i < 20; i++)
            pending_ops.push_back(make_op(ACT_ADDREF, 64'h0, 16'h5, 16'h0));
        wait_drained();
        quiet_phase = 1'b0;

        // random: names from a small pool so lookups hit, handles near live ones
        for (int n = 0; n < 420; n++) begin
            hi = next_hid + 2;
            r = $urandom_range(99);
            if (r < 35)
                pending_ops.push_back(make_op(ACT_LOAD,
                    ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(24)),
                    16'($urandom), 16'($urandom)));
            else if (r < 50)
                pending_ops.push_back(make_op(ACT_ADDREF, {$urandom, $urandom},
                    pick_handle(hi), 16'($urandom)));
            else if (r < 80)
                pending_ops.push_back(make_op(ACT_UNLOAD, {$urandom, $urandom},
                    pick_handle(hi), 16'($urandom)));
            else
                pending_ops.push_back(make_op(ACT_ADDDEP, {$urandom, $urandom},
                    pick_handle(hi), pick_handle(hi)));
            if (n == 210) begin
                wait_drained();
                // unloading the recent handles three times each frees slots for the rest
                hi = next_hid;
                for (int h = (hi > 40) ? hi - 40 : 1; h < hi; h++)
                    for (int k = 0; k < 3; k++)
                        pending_ops.push_back(make_op(ACT_UNLOAD, 64'h0, 16'(h), 16'h0));
                wait_drained();
            end
            if (pending_ops.size() > 4)
                while (pending_ops.size() > 2) @(posedge i_clk);
        end
        wait_drained();
        repeat (60) @(posedge i_clk);

        $display("Ran %0d operations, checked %0d results", ops_sent, results_seen);
        $display("Status mix: ok %0d notfound %0d full %0d depsfull %0d inuse %0d bad %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
